// ----- hdl/mfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magazine free-list cache package
// Shared defaults, request and response codes, and the depot command struct.
// ----------------------------------------------------------------------------
package mfc_pkg;

   localparam int CONTEXTS_DEFAULT     = 8;
   localparam int DEPTH_DEFAULT        = 16;
   localparam int MAGAZINES_DEFAULT    = 64;
   localparam int HANDLE_WIDTH_DEFAULT = 32;

   localparam int KIND_WIDTH    = 1;
   localparam int CTX_WIDTH     = 3;
   localparam int HANDLE_BITS   = 32;
   localparam int STATUS_WIDTH  = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_WIDTH-1:0] KIND_FREE  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_REFUSED   = 2'd3;

   localparam logic UNIT_INC = 1'b0;
   localparam logic UNIT_DEC = 1'b1;

   typedef struct packed {
      logic full_push;
      logic full_pop;
      logic empty_push;
      logic empty_pop;
   } depot_cmd_type;

endpackage

// ----- hdl/mfc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocate or free request.
// ----------------------------------------------------------------------------
interface mfc_req_if;
   logic                                valid;
   logic                                ready;
   logic [mfc_pkg::KIND_WIDTH-1:0]      kind;
   logic [mfc_pkg::CTX_WIDTH-1:0]       context_req;
   logic [mfc_pkg::HANDLE_BITS-1:0]     handle_in;

   modport source (output valid, kind, context_req, handle_in, input ready);
   modport sink (input valid, kind, context_req, handle_in, output ready);
endinterface

// ----- hdl/mfc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one handle and its status.
// ----------------------------------------------------------------------------
interface mfc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mfc_pkg::HANDLE_BITS-1:0]     handle_out;
   logic [mfc_pkg::STATUS_WIDTH-1:0]    status;

   modport source (output valid, handle_out, status, input ready);
   modport sink (input valid, handle_out, status, output ready);
endinterface

// ----- hdl/mfc_fill_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fill counter unit
// Shared increment/decrement unit with zero and full flags for magazine fills.
// ----------------------------------------------------------------------------
module mfc_fill_unit #(
   parameter int DEPTH = mfc_pkg::DEPTH_DEFAULT
) (
   input  logic                       op,
   input  logic [$clog2(DEPTH+1)-1:0] operand,
   output logic [$clog2(DEPTH+1)-1:0] result,
   output logic                       zero,
   output logic                       at_depth
);
   localparam int FW = $clog2(DEPTH+1);

   always_comb begin
      case (op)
         mfc_pkg::UNIT_INC: result = operand + FW'(1);
         mfc_pkg::UNIT_DEC: result = operand - FW'(1);
         default:           result = operand;
      endcase
   end

   assign zero     = (operand == '0);
   assign at_depth = (operand >= FW'(DEPTH));
endmodule

// ----- hdl/mfc_ctx_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Context table
// Front and back magazine numbers and fills for every requesting context.
// ----------------------------------------------------------------------------
module mfc_ctx_table #(
   parameter int CONTEXTS = mfc_pkg::CONTEXTS_DEFAULT,
   parameter int CW       = 3,
   parameter int MW       = 6,
   parameter int FW       = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] rd_ctx,
   output logic [MW-1:0] rd_front,
   output logic [MW-1:0] rd_back,
   output logic [FW-1:0] rd_front_fill,
   output logic [FW-1:0] rd_back_fill,
   input  logic          wr_en,
   input  logic [CW-1:0] wr_ctx,
   input  logic [MW-1:0] wr_front,
   input  logic [MW-1:0] wr_back,
   input  logic [FW-1:0] wr_front_fill,
   input  logic [FW-1:0] wr_back_fill
);
   logic [MW-1:0] front_ff [CONTEXTS];
   logic [MW-1:0] back_ff [CONTEXTS];
   logic [FW-1:0] front_fill_ff [CONTEXTS];
   logic [FW-1:0] back_fill_ff [CONTEXTS];

   assign rd_front      = front_ff[rd_ctx];
   assign rd_back       = back_ff[rd_ctx];
   assign rd_front_fill = front_fill_ff[rd_ctx];
   assign rd_back_fill  = back_fill_ff[rd_ctx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CONTEXTS; c++) begin
            front_ff[c]      <= MW'(2 * c);
            back_ff[c]       <= MW'(2 * c + 1);
            front_fill_ff[c] <= '0;
            back_fill_ff[c]  <= '0;
         end
      end else if (wr_en) begin
         front_ff[wr_ctx]      <= wr_front;
         back_ff[wr_ctx]       <= wr_back;
         front_fill_ff[wr_ctx] <= wr_front_fill;
         back_fill_ff[wr_ctx]  <= wr_back_fill;
      end
   end
endmodule

// ----- hdl/mfc_elem_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element store
// Handle memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfc_elem_store #(
   parameter int ENTRIES = 1024,
   parameter int AW      = 10,
   parameter int HW      = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [HW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [HW-1:0] rd_data
);
   logic [HW-1:0] mem [ENTRIES];
   logic [HW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/mfc_depot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magazine depot
// LIFO stacks of full and empty magazines with registered pop data. A pop of an empty
// slot below the low-water mark of writes returns its reset magazine, 2 * CONTEXTS + index.
// ----------------------------------------------------------------------------
module mfc_depot #(
   parameter int POOL     = 64,
   parameter int CONTEXTS = mfc_pkg::CONTEXTS_DEFAULT,
   parameter int MW       = 6,
   parameter int SW       = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mfc_pkg::depot_cmd_type cmd,
   input  logic [MW-1:0]          push_data,
   output logic [SW-1:0]          full_size,
   output logic [SW-1:0]          empty_size,
   output logic [MW-1:0]          full_top,
   output logic [MW-1:0]          empty_top
);
   localparam int SPARE = POOL - 2 * CONTEXTS;

   logic [MW-1:0] full_mem [POOL];
   logic [MW-1:0] empty_mem [POOL];
   logic [SW-1:0] full_size_ff, full_size_in;
   logic [SW-1:0] empty_size_ff, empty_size_in;
   logic [SW-1:0] mark_ff, mark_in;
   logic [MW-1:0] full_q_ff;
   logic [MW-1:0] empty_q_ff;
   logic [MW-1:0] orig_q_ff;
   logic          orig_sel_ff;
   logic [SW-1:0] full_dec;
   logic [SW-1:0] empty_dec;

   assign full_dec  = full_size_ff - SW'(1);
   assign empty_dec = empty_size_ff - SW'(1);

   always_comb begin
      full_size_in  = full_size_ff;
      empty_size_in = empty_size_ff;
      mark_in       = mark_ff;
      if (cmd.full_push) begin
         full_size_in = full_size_ff + SW'(1);
      end else if (cmd.full_pop) begin
         full_size_in = full_dec;
      end
      if (cmd.empty_push) begin
         empty_size_in = empty_size_ff + SW'(1);
         if (empty_size_ff < mark_ff) begin
            mark_in = empty_size_ff;
         end
      end else if (cmd.empty_pop) begin
         empty_size_in = empty_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_size_ff  <= '0;
         empty_size_ff <= SW'(SPARE);
         mark_ff       <= SW'(SPARE);
      end else begin
         full_size_ff  <= full_size_in;
         empty_size_ff <= empty_size_in;
         mark_ff       <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.full_push) begin
         full_mem[full_size_ff[MW-1:0]] <= push_data;
      end
      if (cmd.full_pop) begin
         full_q_ff <= full_mem[full_dec[MW-1:0]];
      end
      if (cmd.empty_push) begin
         empty_mem[empty_size_ff[MW-1:0]] <= push_data;
      end
      if (cmd.empty_pop) begin
         empty_q_ff  <= empty_mem[empty_dec[MW-1:0]];
         orig_q_ff   <= MW'(2 * CONTEXTS + int'(empty_dec));
         orig_sel_ff <= (empty_dec < mark_ff);
      end
   end

   assign full_size  = full_size_ff;
   assign empty_size = empty_size_ff;
   assign full_top   = full_q_ff;
   assign empty_top  = orig_sel_ff ? orig_q_ff : empty_q_ff;
endmodule

// ----- hdl/magazine_free_list_cache.sv -----
`timescale 1ns / 1ps
// Steps: a free runs load, free-put and free-check before done (a refused free skips the
// check); an allocate runs load, alloc-check, alloc-pop and alloc-read before done (a pop
// that finds nothing skips the read); a depot exchange adds an exchange step, and a context
// out of range goes from load straight to done. One request is in work at a time and the
// sequencer returns to idle after each; a waiting response stalls only the last step.
// Reset is synchronous; no clearing pass follows it.
// ----------------------------------------------------------------------------
// Magazine free-list cache
// Per-context front/back magazines of element handles backed by a shared
// depot of full and empty magazines, run by a multi-cycle sequencer.
// ----------------------------------------------------------------------------
module magazine_free_list_cache #(
   parameter int CONTEXTS     = mfc_pkg::CONTEXTS_DEFAULT,
   parameter int DEPTH        = mfc_pkg::DEPTH_DEFAULT,
   parameter int MAGAZINES    = mfc_pkg::MAGAZINES_DEFAULT,
   parameter int HANDLE_WIDTH = mfc_pkg::HANDLE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mfc_req_if.sink   req_ch,
   mfc_rsp_if.source rsp_ch
);
   localparam int POOL = (MAGAZINES > 2 * CONTEXTS) ? MAGAZINES : 2 * CONTEXTS;
   localparam int CW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int MW   = $clog2(POOL);
   localparam int FW   = $clog2(DEPTH + 1);
   localparam int SW   = $clog2(POOL + 1);
   localparam int AW   = $clog2(POOL * DEPTH);
   localparam int HW   = (HANDLE_WIDTH < mfc_pkg::HANDLE_BITS) ?
                         HANDLE_WIDTH : mfc_pkg::HANDLE_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_LOAD      = 4'd1;
   localparam logic [3:0] S_ALLOC_CHK = 4'd2;
   localparam logic [3:0] S_ALLOC_XCH = 4'd3;
   localparam logic [3:0] S_ALLOC_POP = 4'd4;
   localparam logic [3:0] S_ALLOC_RD  = 4'd5;
   localparam logic [3:0] S_FREE_PUT  = 4'd6;
   localparam logic [3:0] S_FREE_CHK  = 4'd7;
   localparam logic [3:0] S_FREE_XCH  = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [mfc_pkg::KIND_WIDTH-1:0]  kind_ff, kind_in;
   logic [mfc_pkg::CTX_WIDTH-1:0]   ctx_ff, ctx_in;
   logic [HW-1:0]                   hin_ff, hin_in;
   logic [MW-1:0] front_ff, front_in;
   logic [MW-1:0] back_ff, back_in;
   logic [FW-1:0] ffill_ff, ffill_in;
   logic [FW-1:0] bfill_ff, bfill_in;
   logic          in_range_ff, in_range_in;
   logic [mfc_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic [mfc_pkg::HANDLE_BITS-1:0]  hout_ff, hout_in;
   logic [mfc_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [mfc_pkg::HANDLE_BITS-1:0]  rsp_hout_ff, rsp_hout_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] ctx_idx;
   logic [MW-1:0] tbl_front, tbl_back;
   logic [FW-1:0] tbl_ffill, tbl_bfill;
   logic          tbl_wr;

   logic          unit_op;
   logic [FW-1:0] unit_operand, unit_result;
   logic          unit_zero, unit_at_depth;

   mfc_pkg::depot_cmd_type depot_cmd;
   logic [MW-1:0] depot_push;
   logic [SW-1:0] full_size, empty_size;
   logic [MW-1:0] full_top, empty_top;

   logic          es_wr, es_rd;
   logic [AW-1:0] es_wr_addr, es_rd_addr;
   logic [HW-1:0] es_rd_data;

   logic          done_go;
   logic          front_full, back_full, pair_full;

   assign ctx_idx    = CW'(ctx_ff);
   assign front_full = (ffill_ff >= FW'(DEPTH));
   assign back_full  = (bfill_ff >= FW'(DEPTH));
   assign pair_full  = (ffill_ff == FW'(DEPTH)) && (bfill_ff == FW'(DEPTH));
   assign done_go    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign tbl_wr     = done_go && in_range_ff;

   mfc_ctx_table #(
      .CONTEXTS (CONTEXTS),
      .CW       (CW),
      .MW       (MW),
      .FW       (FW)
   ) u_ctx_table (
      .clock         (clock),
      .reset         (reset),
      .rd_ctx        (ctx_idx),
      .rd_front      (tbl_front),
      .rd_back       (tbl_back),
      .rd_front_fill (tbl_ffill),
      .rd_back_fill  (tbl_bfill),
      .wr_en         (tbl_wr),
      .wr_ctx        (ctx_idx),
      .wr_front      (front_ff),
      .wr_back       (back_ff),
      .wr_front_fill (ffill_ff),
      .wr_back_fill  (bfill_ff)
   );

   mfc_fill_unit #(
      .DEPTH (DEPTH)
   ) u_fill_unit (
      .op       (unit_op),
      .operand  (unit_operand),
      .result   (unit_result),
      .zero     (unit_zero),
      .at_depth (unit_at_depth)
   );

   mfc_depot #(
      .POOL     (POOL),
      .CONTEXTS (CONTEXTS),
      .MW       (MW),
      .SW       (SW)
   ) u_depot (
      .clock      (clock),
      .reset      (reset),
      .cmd        (depot_cmd),
      .push_data  (depot_push),
      .full_size  (full_size),
      .empty_size (empty_size),
      .full_top   (full_top),
      .empty_top  (empty_top)
   );

   mfc_elem_store #(
      .ENTRIES (POOL * DEPTH),
      .AW      (AW),
      .HW      (HW)
   ) u_elem_store (
      .clock   (clock),
      .wr_en   (es_wr),
      .wr_addr (es_wr_addr),
      .wr_data (hin_ff),
      .rd_en   (es_rd),
      .rd_addr (es_rd_addr),
      .rd_data (es_rd_data)
   );

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.handle_out = rsp_hout_ff;
   assign rsp_ch.status     = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      ctx_in        = ctx_ff;
      hin_in        = hin_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      ffill_in      = ffill_ff;
      bfill_in      = bfill_ff;
      in_range_in   = in_range_ff;
      status_in     = status_ff;
      hout_in       = hout_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hout_in   = rsp_hout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      unit_op       = mfc_pkg::UNIT_DEC;
      unit_operand  = ffill_ff;
      depot_cmd     = '0;
      depot_push    = front_ff;
      es_wr         = 1'b0;
      es_rd         = 1'b0;
      es_wr_addr    = AW'(int'(front_ff) * DEPTH + int'(ffill_ff));
      es_rd_addr    = AW'(int'(front_ff) * DEPTH + int'(unit_result));

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in  = req_ch.kind;
               ctx_in   = req_ch.context_req;
               hin_in   = req_ch.handle_in[HW-1:0];
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            in_range_in = (int'(ctx_ff) < CONTEXTS);
            status_in   = mfc_pkg::STATUS_OK;
            hout_in     = '0;
            front_in    = tbl_front;
            back_in     = tbl_back;
            ffill_in    = tbl_ffill;
            bfill_in    = tbl_bfill;
            if (int'(ctx_ff) >= CONTEXTS) begin
               status_in = (kind_ff == mfc_pkg::KIND_FREE) ?
                           mfc_pkg::STATUS_REFUSED : mfc_pkg::STATUS_EMPTY;
               state_in  = S_DONE;
            end else if (kind_ff == mfc_pkg::KIND_FREE) begin
               state_in = S_FREE_PUT;
            end else begin
               state_in = S_ALLOC_CHK;
            end
         end
         S_ALLOC_CHK: begin
            if (ffill_ff == '0 && bfill_ff == '0 && full_size != '0 &&
                empty_size < SW'(POOL)) begin
               depot_cmd.full_pop   = 1'b1;
               depot_cmd.empty_push = 1'b1;
               depot_push           = front_ff;
               state_in             = S_ALLOC_XCH;
            end else begin
               state_in = S_ALLOC_POP;
            end
         end
         S_ALLOC_XCH: begin
            front_in = full_top;
            ffill_in = FW'(DEPTH);
            state_in = S_ALLOC_POP;
         end
         S_ALLOC_POP: begin
            unit_op      = mfc_pkg::UNIT_DEC;
            unit_operand = ffill_ff;
            if (unit_zero) begin
               status_in = mfc_pkg::STATUS_EMPTY;
               state_in  = S_DONE;
            end else begin
               ffill_in = unit_result;
               es_rd    = 1'b1;
               state_in = S_ALLOC_RD;
            end
         end
         S_ALLOC_RD: begin
            hout_in         = '0;
            hout_in[HW-1:0] = es_rd_data;
            if (ffill_ff == '0) begin
               front_in = back_ff;
               back_in  = front_ff;
               ffill_in = bfill_ff;
               bfill_in = ffill_ff;
            end
            state_in = S_DONE;
         end
         S_FREE_PUT: begin
            unit_op = mfc_pkg::UNIT_INC;
            if (front_full && back_full) begin
               status_in = mfc_pkg::STATUS_REFUSED;
               state_in  = S_DONE;
            end else if (!front_full) begin
               unit_operand = ffill_ff;
               es_wr        = 1'b1;
               es_wr_addr   = AW'(int'(front_ff) * DEPTH + int'(ffill_ff));
               ffill_in     = unit_result;
               state_in     = S_FREE_CHK;
            end else begin
               unit_operand = bfill_ff;
               es_wr        = 1'b1;
               es_wr_addr   = AW'(int'(back_ff) * DEPTH + int'(bfill_ff));
               bfill_in     = unit_result;
               state_in     = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            unit_operand = bfill_ff;
            if (pair_full && unit_at_depth) begin
               if (empty_size != '0 && full_size < SW'(POOL)) begin
                  depot_cmd.full_push = 1'b1;
                  depot_cmd.empty_pop = 1'b1;
                  depot_push          = back_ff;
                  state_in            = S_FREE_XCH;
               end else begin
                  status_in = mfc_pkg::STATUS_EXHAUSTED;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_XCH: begin
            back_in  = empty_top;
            bfill_in = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_hout_in   = hout_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         in_range_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         in_range_ff  <= in_range_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ctx_ff        <= ctx_in;
      hin_ff        <= hin_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      ffill_ff      <= ffill_in;
      bfill_ff      <= bfill_in;
      status_ff     <= status_in;
      hout_ff       <= hout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hout_ff   <= rsp_hout_in;
   end

`ifndef SYNTHESIS
   // Every magazine not held by a context sits in exactly one depot stack.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, full_size} + {1'b0, empty_size}) == (SW + 1)'(POOL - 2 * CONTEXTS))
      else $error("depot magazine count is not conserved");

   // A response that is not ok never carries a handle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != mfc_pkg::STATUS_OK) |-> (rsp_hout_ff == '0))
      else $error("handle returned with a failing status");

   // A request transfer always starts the context lookup.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_LOAD))
      else $error("request transfer did not start a lookup");

   // A response only appears as the sequencer leaves its final step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE && state_ff == S_IDLE))
      else $error("response raised outside the final step");
`endif
endmodule
